### sv/cct_pkg.sv
// ----------------------------------------------------------------------------
// Calendar clock package
// Shared types, limits and the month-length and leap-year helpers used by the
// calendar clock tick unit.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int unsigned SEC_W   = 6;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;

    localparam logic [YEAR_W-1:0]  YEAR_MIN    = YEAR_W'(2000);
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = YEAR_W'(9999);
    localparam logic [SEC_W-1:0]   SEC_LAST    = SEC_W'(59);
    localparam logic [MIN_W-1:0]   MIN_LAST    = MIN_W'(59);
    localparam logic [HOUR_W-1:0]  HOUR_LAST   = HOUR_W'(23);
    localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_LAST  = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST   = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_LEAP_FEB = DAY_W'(29);

    // Multiplicative inverse of 25 modulo 2^14 and the largest product that
    // a multiple of 25 can give: an exact divisibility test with one multiply.
    localparam logic [YEAR_W-1:0]  INV25       = YEAR_W'(7209);
    localparam logic [YEAR_W-1:0]  DIV25_LIMIT = YEAR_W'(16383 / 25);

    // Op codes of an input item
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // One date and time
    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_time;

    // Length of a month in a common year; month codes outside 1..12 give 31.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon);
        logic [DAY_W-1:0] len;
        case (mon)
            4'd2:                      len = DAY_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
            default:                   len = DAY_W'(31);
        endcase
        return len;
    endfunction

    // Days in a month, given whether the year is a leap year.
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] mon,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        if (mon == MONTH_FEB && leap) begin
            len = DAY_LEAP_FEB;
        end else begin
            len = month_len(mon);
        end
        return len;
    endfunction

    // Gregorian leap year: divisible by 4 and either not by 25 or also by 16.
    // Only the low 14 bits of the product matter for the divisibility test.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

endpackage

### sv/calendar_clock_tick_unit.sv
// ----------------------------------------------------------------------------
// Calendar clock tick unit
// Real-time clock and calendar: second, minute, hour, day, month and year,
// advanced one second per tick item or loaded with checked values.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid / o_ready) carries one item per transfer: a
// one-second tick (i_op low) or a load of all six fields (i_op high). Loaded
// values out of range are replaced: month and day by 1, hour, minute and
// second by 0, and the year is held within 2000..9999. Each item yields one
// result on the output channel (o_valid / i_ready): the date and time after
// that item.
// Each result is registered in the output register, or in the skid register
// while the receiver stalls. Throughput is one item per cycle while o_ready
// is high, set by the single pass of compares and increments between the
// time registers and the output register; leap years use one 14-bit multiply.
// A skid register behind the output register lets one more item be taken
// while the receiver stalls; o_ready then drops until the skid register
// drains. Reset empties both and sets the clock to 00:00:00, 1 January 2000.
// ----------------------------------------------------------------------------
module calendar_clock_tick_unit
    import cct_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Item channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [MONTH_W-1:0] i_load_month,
    input  logic [DAY_W-1:0]   i_load_day,
    input  logic [YEAR_W-1:0]  i_load_year,
    input  logic [HOUR_W-1:0]  i_load_hour,
    input  logic [MIN_W-1:0]   i_load_minute,
    input  logic [SEC_W-1:0]   i_load_second,
    // Result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SEC_W-1:0]   o_cur_second,
    output logic [MIN_W-1:0]   o_cur_minute,
    output logic [HOUR_W-1:0]  o_cur_hour,
    output logic [DAY_W-1:0]   o_cur_day,
    output logic [MONTH_W-1:0] o_cur_month,
    output logic [YEAR_W-1:0]  o_cur_year
);

    // Time of day and date, plus the leap flag of the current year
    t_time r_time, n_time;
    logic  r_leap, n_leap;

    // Output register and skid register
    t_time r_out, r_skd;
    logic  r_out_valid, r_skd_valid;

    logic  in_xfer, out_xfer;

    // Load path signals
    logic [MONTH_W-1:0] ld_month;
    logic [YEAR_W-1:0]  ld_year;
    logic               ld_leap;
    logic [DAY_W-1:0]   ld_day;

    // Tick path signals
    logic               sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
    logic [YEAR_W-1:0]  year_inc;
    logic               year_step;

    assign o_ready  = !r_skd_valid;
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = r_out_valid && i_ready;

    // Load: check each field and replace what is out of range
    always_comb begin
        if (i_load_month < MONTH_FIRST || i_load_month > MONTH_LAST) begin
            ld_month = MONTH_FIRST;
        end else begin
            ld_month = i_load_month;
        end
        if (i_load_year < YEAR_MIN) begin
            ld_year = YEAR_MIN;
        end else if (i_load_year > YEAR_MAX) begin
            ld_year = YEAR_MAX;
        end else begin
            ld_year = i_load_year;
        end
        ld_leap = is_leap(ld_year);
        if (i_load_day == '0 || i_load_day > days_in(ld_month, ld_leap)) begin
            ld_day = DAY_FIRST;
        end else begin
            ld_day = i_load_day;
        end
    end

    // Tick: carry chain from seconds up to the year
    assign sec_wrap   = (r_time.second == SEC_LAST);
    assign min_wrap   = sec_wrap && (r_time.minute == MIN_LAST);
    assign hour_wrap  = min_wrap && (r_time.hour == HOUR_LAST);
    assign day_wrap   = hour_wrap && (r_time.day >= days_in(r_time.month, r_leap));
    assign month_wrap = day_wrap && (r_time.month >= MONTH_LAST);
    assign year_step  = month_wrap && (r_time.year < YEAR_MAX);
    assign year_inc   = r_time.year + YEAR_W'(1);

    // Next state for the item being transferred
    always_comb begin
        n_time = r_time;
        n_leap = r_leap;
        if (i_op == OP_LOAD) begin
            n_time.month  = ld_month;
            n_time.year   = ld_year;
            n_time.day    = ld_day;
            n_time.hour   = (i_load_hour <= HOUR_LAST)  ? i_load_hour   : '0;
            n_time.minute = (i_load_minute <= MIN_LAST) ? i_load_minute : '0;
            n_time.second = (i_load_second <= SEC_LAST) ? i_load_second : '0;
            n_leap        = ld_leap;
        end else begin
            n_time.second = sec_wrap ? '0 : r_time.second + SEC_W'(1);
            if (sec_wrap) begin
                n_time.minute = min_wrap ? '0 : r_time.minute + MIN_W'(1);
            end
            if (min_wrap) begin
                n_time.hour = hour_wrap ? '0 : r_time.hour + HOUR_W'(1);
            end
            if (hour_wrap) begin
                n_time.day = day_wrap ? DAY_FIRST : r_time.day + DAY_W'(1);
            end
            if (day_wrap) begin
                n_time.month = month_wrap ? MONTH_FIRST : r_time.month + MONTH_W'(1);
            end
            if (year_step) begin
                n_time.year = year_inc;
                n_leap      = is_leap(year_inc);
            end
        end
    end

    // Clock and calendar registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.second <= '0;
            r_time.minute <= '0;
            r_time.hour   <= '0;
            r_time.day    <= DAY_FIRST;
            r_time.month  <= MONTH_FIRST;
            r_time.year   <= YEAR_MIN;
            r_leap        <= 1'b1;
        end else if (in_xfer) begin
            r_time <= n_time;
            r_leap <= n_leap;
        end
    end

    // Output and skid valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (r_skd_valid) begin
                if (out_xfer) begin
                    r_skd_valid <= 1'b0;
                end
            end else if (in_xfer) begin
                if (r_out_valid && !i_ready) begin
                    r_skd_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (out_xfer) begin
                r_out <= r_skd;
            end
        end else if (in_xfer) begin
            if (r_out_valid && !i_ready) begin
                r_skd <= n_time;
            end else begin
                r_out <= n_time;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cur_second = r_out.second;
    assign o_cur_minute = r_out.minute;
    assign o_cur_hour   = r_out.hour;
    assign o_cur_day    = r_out.day;
    assign o_cur_month  = r_out.month;
    assign o_cur_year   = r_out.year;

    // The skid register only fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // Every result holds a valid time of day.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cur_second <= SEC_LAST && o_cur_minute <= MIN_LAST &&
                     o_cur_hour <= HOUR_LAST))
        else $error("time of day out of range");

    // Every result holds a valid date.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cur_month >= MONTH_FIRST && o_cur_month <= MONTH_LAST &&
                     o_cur_day >= DAY_FIRST && o_cur_year >= YEAR_MIN &&
                     o_cur_year <= YEAR_MAX))
        else $error("date out of range");

    // A tick that does not wrap the seconds only bumps the seconds.
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_op == OP_TICK && !sec_wrap) |=>
            (r_time.second == $past(r_time.second) + SEC_W'(1) &&
             r_time.minute == $past(r_time.minute)))
        else $error("tick without carry changed more than the seconds");

endmodule
